[hdl/bpfd_pkg.sv]
package bpfd_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned SRC_W     = 16;
  localparam int unsigned DST_W     = 16;
  localparam int unsigned TS_W      = 30;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned MCOUNT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [SRC_W-1:0] source;
    logic [DST_W-1:0] destination;
    logic [TS_W-1:0]  timestamp;
    logic [TS_W-1:0]  start_time;
    logic [TS_W-1:0]  end_time;
  } in_t;

  typedef struct packed {
    logic                ok;
    logic [SRC_W-1:0]    out_source;
    logic [DST_W-1:0]    out_destination;
    logic [TS_W-1:0]     out_timestamp;
    logic [MCOUNT_W-1:0] match_count;
  } out_t;

  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic [DST_W-1:0] destination;
    logic [TS_W-1:0]  timestamp;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch request, rewind scan to head
    logic scan_issue;  // read entry at scan pointer, advance
    logic commit;      // write new entry at tail, drop oldest at the limit
    logic load_out;    // load result register
    logic pop;         // drop oldest entry after forward
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_more;
    logic            occ_nz;
    logic            dup;
  } status_t;

endpackage

[hdl/bpfd_dpath.sv]
module bpfd_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpfd_pkg::LIMIT_W-1:0]  cfg_data_i,
  input  bpfd_pkg::in_t                 in_data_i,
  input  bpfd_pkg::cmd_t                cmd_i,
  output bpfd_pkg::status_t             status_o,
  output bpfd_pkg::out_t                out_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W =
    ((OCC_W > bpfd_pkg::LIMIT_W) ? OCC_W : bpfd_pkg::LIMIT_W) + 1;

  logic [bpfd_pkg::LIMIT_W-1:0] limit_q;
  bpfd_pkg::in_t                req_q;
  logic [PTR_W-1:0]             head_q, tail_q, scan_ptr_q;
  logic [OCC_W-1:0]             occ_q, scan_cnt_q, match_q;
  logic                         dup_q, rd_vld_q;
  bpfd_pkg::entry_t             rd_data_q;
  bpfd_pkg::out_t               out_q, out_d;

  bpfd_pkg::entry_t             mem [DEPTH];

  logic [CMP_W-1:0]             lim_ext, depth_ext, occ_ext, eff_limit;
  logic                         drop;
  logic                         hit_dup, hit_cnt;
  bpfd_pkg::entry_t             entry_new;
  logic [OCC_W+bpfd_pkg::MCOUNT_W-1:0] match_ext;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Effective limit: zero acts as one, clip at the store depth
  assign lim_ext   = CMP_W'(limit_q);
  assign depth_ext = CMP_W'(DEPTH);
  assign occ_ext   = CMP_W'(occ_q);
  always_comb begin
    if (limit_q == '0) begin
      eff_limit = CMP_W'(1);
    end else if (lim_ext > depth_ext) begin
      eff_limit = depth_ext;
    end else begin
      eff_limit = lim_ext;
    end
  end
  assign drop = (occ_ext >= eff_limit) || (occ_ext >= depth_ext);

  assign entry_new.source      = req_q.source;
  assign entry_new.destination = req_q.destination;
  assign entry_new.timestamp   = req_q.timestamp;

  assign hit_dup = rd_vld_q && (rd_data_q == entry_new);
  assign hit_cnt = rd_vld_q && (rd_data_q.destination == req_q.destination) &&
                   (rd_data_q.timestamp >= req_q.start_time) &&
                   (rd_data_q.timestamp <= req_q.end_time);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bpfd_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
  end

  // Entry store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem[tail_q] <= entry_new;
    end
    if (cmd_i.scan_issue) begin
      rd_data_q <= mem[scan_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= '0;
      scan_ptr_q <= '0;
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      dup_q      <= 1'b0;
      match_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;

      if (cmd_i.capture) begin
        scan_ptr_q <= head_q;
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_ptr_q <= next_ptr(scan_ptr_q);
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end

      if (cmd_i.capture) begin
        dup_q   <= 1'b0;
        match_q <= '0;
      end else begin
        dup_q   <= dup_q | hit_dup;
        match_q <= match_q + OCC_W'(hit_cnt);
      end

      if (cmd_i.commit) begin
        tail_q <= next_ptr(tail_q);
        if (drop) begin
          head_q <= next_ptr(head_q);
        end else begin
          occ_q <= occ_q + 1'b1;
        end
      end else if (cmd_i.pop) begin
        head_q <= next_ptr(head_q);
        occ_q  <= occ_q - 1'b1;
      end
    end
  end

  assign match_ext = {{bpfd_pkg::MCOUNT_W{1'b0}}, match_q};

  always_comb begin
    out_d = '0;
    unique case (req_q.operation)
      bpfd_pkg::OP_ADD: begin
        out_d.ok = !dup_q;
      end
      bpfd_pkg::OP_FWD: begin
        if (occ_q != '0) begin
          out_d.ok              = 1'b1;
          out_d.out_source      = rd_data_q.source;
          out_d.out_destination = rd_data_q.destination;
          out_d.out_timestamp   = rd_data_q.timestamp;
        end
      end
      bpfd_pkg::OP_COUNT: begin
        out_d.match_count = match_ext[bpfd_pkg::MCOUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  assign status_o.op        = req_q.operation;
  assign status_o.scan_more = (scan_cnt_q < occ_q);
  assign status_o.occ_nz    = (occ_q != '0);
  assign status_o.dup       = dup_q;

endmodule

[hdl/bpfd_ctrl.sv]
module bpfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bpfd_pkg::status_t status_i,
  output bpfd_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_FIN    = 3'd3;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        unique case (status_i.op)
          bpfd_pkg::OP_ADD, bpfd_pkg::OP_COUNT: begin
            if (status_i.scan_more) begin
              cmd_o.scan_issue = 1'b1;
            end else if (status_i.op == bpfd_pkg::OP_ADD) begin
              state_d = ST_COMMIT;
            end else begin
              state_d = ST_FIN;
            end
          end
          bpfd_pkg::OP_FWD: begin
            // read the head entry, data lands for the result stage
            cmd_o.scan_issue = status_i.occ_nz;
            state_d          = ST_FIN;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_COMMIT: begin
        cmd_o.commit = !status_i.dup;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          cmd_o.pop      = (status_i.op == bpfd_pkg::OP_FWD) && status_i.occ_nz;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/bounded_packet_fifo_dedup_count_unit.sv]
// Channel   Signals                               Dir  Payload
// input     in_valid_i / in_ready_o / in_data_i   in   bpfd_pkg::in_t
// output    out_valid_o / out_ready_i / out_data_o out bpfd_pkg::out_t
// config    cfg_we_i / cfg_data_i                 in   memory_limit, 7 bits
//
// One item at a time. An add or count scans every stored entry through the
// single read port of the entry store, one entry a cycle; an add then has a
// commit step for the write, and a forward reads only the head entry. Reset
// clears pointers and occupancy and sets the limit to 64; the store itself is
// not cleared. A new item is taken while the previous result still waits in
// the output register.
module bounded_packet_fifo_dedup_count_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bpfd_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bpfd_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [bpfd_pkg::LIMIT_W-1:0]  cfg_data_i
);

  bpfd_pkg::cmd_t    cmd;
  bpfd_pkg::status_t status;

  // Sequence capture, scan, commit and result load
  bpfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the entry store, pointers, compare logic and result register
  bpfd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  // Accepting an item closes the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accept");

  // Never overwrite a result that has not been taken
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // Only a non-duplicate add writes the store
  a_commit_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (status.op == bpfd_pkg::OP_ADD) && !status.dup)
    else $error("store written on wrong operation");

  // Reads stay within the occupied entries
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_issue |-> status.scan_more)
    else $error("scan read past occupancy");

endmodule

[verif/bpfd_result_checker.sv]
`timescale 1ns / 100ps

module bpfd_result_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  bpfd_pkg::in_t                 in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  bpfd_pkg::out_t                out_data_i,
  input  logic                          cfg_we_i,
  input  logic [bpfd_pkg::LIMIT_W-1:0]  cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  typedef logic [bpfd_pkg::MCOUNT_W-1:0] mcount_t;
  typedef logic [127:0]                  wide_t;

  // Shadow copy of the packet store
  bpfd_pkg::entry_t              packet_mem [DEPTH];
  int unsigned                   oldest_idx;
  int unsigned                   free_idx;
  int unsigned                   stored_count;
  logic [bpfd_pkg::LIMIT_W-1:0]  limit_reg;

  bpfd_pkg::out_t                result_q [$];
  bpfd_pkg::out_t                wanted;

  task automatic report_mismatch(input string what, input wide_t got, input wide_t want);
    fail_count_o++;
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic bpfd_pkg::out_t apply_packet_op(input bpfd_pkg::in_t item);
    bpfd_pkg::out_t   res;
    bpfd_pkg::entry_t incoming;
    bit               seen;
    int unsigned      idx;
    int unsigned      cap;
    int unsigned      hits;
    res = '0;
    incoming.source      = item.source;
    incoming.destination = item.destination;
    incoming.timestamp   = item.timestamp;
    cap = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : limit_reg);
    case (item.operation)
      bpfd_pkg::OP_ADD: begin
        // duplicate search covers the entry an insert would evict
        seen = 1'b0;
        idx  = oldest_idx;
        for (int n = 0; n < stored_count; n++) begin
          if (packet_mem[idx] == incoming) seen = 1'b1;
          idx = (idx + 1) % DEPTH;
        end
        if (!seen) begin
          if ((stored_count + 1 > cap || stored_count >= DEPTH) && stored_count != 0) begin
            oldest_idx = (oldest_idx + 1) % DEPTH;
            stored_count--;
          end
          packet_mem[free_idx] = incoming;
          free_idx = (free_idx + 1) % DEPTH;
          stored_count++;
          res.ok = 1'b1;
        end
      end
      bpfd_pkg::OP_FWD: begin
        if (stored_count != 0) begin
          res.ok              = 1'b1;
          res.out_source      = packet_mem[oldest_idx].source;
          res.out_destination = packet_mem[oldest_idx].destination;
          res.out_timestamp   = packet_mem[oldest_idx].timestamp;
          oldest_idx = (oldest_idx + 1) % DEPTH;
          stored_count--;
        end
      end
      bpfd_pkg::OP_COUNT: begin
        hits = 0;
        idx  = oldest_idx;
        for (int n = 0; n < stored_count; n++) begin
          if (packet_mem[idx].destination == item.destination &&
              packet_mem[idx].timestamp >= item.start_time &&
              packet_mem[idx].timestamp <= item.end_time) begin
            hits++;
          end
          idx = (idx + 1) % DEPTH;
        end
        res.match_count = mcount_t'(hits);
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_idx   = 0;
      free_idx     = 0;
      stored_count = 0;
      limit_reg    = bpfd_pkg::LIMIT_RESET;
      result_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) limit_reg = cfg_data_i;
      // check the result leaving now before queueing the item entering now
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", wide_t'(out_data_i), '0);
        end else begin
          wanted = result_q.pop_front();
          if (out_data_i.ok !== wanted.ok)
            report_mismatch("ok", wide_t'(out_data_i.ok), wide_t'(wanted.ok));
          if (out_data_i.out_source !== wanted.out_source)
            report_mismatch("out_source", wide_t'(out_data_i.out_source),
                            wide_t'(wanted.out_source));
          if (out_data_i.out_destination !== wanted.out_destination)
            report_mismatch("out_destination", wide_t'(out_data_i.out_destination),
                            wide_t'(wanted.out_destination));
          if (out_data_i.out_timestamp !== wanted.out_timestamp)
            report_mismatch("out_timestamp", wide_t'(out_data_i.out_timestamp),
                            wide_t'(wanted.out_timestamp));
          if (out_data_i.match_count !== wanted.match_count)
            report_mismatch("match_count", wide_t'(out_data_i.match_count),
                            wide_t'(wanted.match_count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.insert(result_q.size(), apply_packet_op(in_data_i));
      end
      pending_o = result_q.size();
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef logic [bpfd_pkg::SRC_W-1:0] src_t;
  typedef logic [bpfd_pkg::DST_W-1:0] dst_t;
  typedef logic [bpfd_pkg::TS_W-1:0]  ts_t;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned ITEMS_PER_SEG  = 122;
  localparam int unsigned SEGMENTS       = 9;
  localparam logic [bpfd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam ts_t                       TS_MAX    = '1;
  localparam dst_t                      FLOOD_DST = 16'hA5A5;

  // Traffic shapes for the random part
  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN,
    MIX_FLOOD
  } traffic_mix_e;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  bpfd_pkg::in_t                 in_data;
  logic                          out_valid;
  logic                          out_ready;
  bpfd_pkg::out_t                out_data;
  logic                          cfg_we;
  logic [bpfd_pkg::LIMIT_W-1:0]  cfg_data;

  int unsigned        fail_count;
  int unsigned        pending_results;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        idle_cycles;
  ts_t                flood_ts;

  // Limit settings per random segment: reset value, clamp cases, lowering cases
  logic [bpfd_pkg::LIMIT_W-1:0] limit_plan [SEGMENTS] = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd0,
                                                          7'd64, 7'd2, 7'd100, 7'd33};

  bounded_packet_fifo_dedup_count_unit #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  bpfd_result_checker #(
    .DEPTH (DEPTH)
  ) result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drive every input to a known value from time zero
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
  end

  // Receiver: decide readiness afresh at every falling edge
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic src_t rand_id();
    return src_t'($urandom);
  endfunction

  function automatic ts_t rand_ts();
    return ts_t'($urandom);
  endfunction

  // Build one item; fields the operation ignores carry whatever the caller passes
  function automatic bpfd_pkg::in_t make_item(input logic [bpfd_pkg::OP_W-1:0] op,
                                              input src_t src, input dst_t dst,
                                              input ts_t ts, input ts_t lo, input ts_t hi);
    bpfd_pkg::in_t item;
    item.operation   = op;
    item.source      = src;
    item.destination = dst;
    item.timestamp   = ts;
    item.start_time  = lo;
    item.end_time    = hi;
    return item;
  endfunction

  // Identifiers come mostly from a tiny pool so duplicates and count hits are common
  function automatic src_t pick_id();
    if ($urandom_range(99) < 15) return rand_id();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Timestamps cluster at both ends of the range
  function automatic ts_t pick_time();
    int unsigned k;
    if ($urandom_range(99) < 15) return rand_ts();
    k = $urandom_range(7);
    return (k < 4) ? ts_t'(k) : TS_MAX - ts_t'(k - 4);
  endfunction

  function automatic ts_t pick_bound();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return $urandom_range(1) ? TS_MAX : '0;
    if (r < 60) return pick_time();
    return rand_ts();
  endfunction

  function automatic bpfd_pkg::in_t random_item(input traffic_mix_e mix);
    int unsigned r;
    int unsigned add_lim;
    int unsigned fwd_lim;
    int unsigned cnt_lim;
    r = $urandom_range(99);
    if (mix == MIX_FLOOD) begin
      // fill with one destination and fresh timestamps, then count them all
      if (r < 85) begin
        flood_ts++;
        return make_item(bpfd_pkg::OP_ADD, rand_id(), FLOOD_DST, flood_ts,
                         rand_ts(), rand_ts());
      end
      return make_item(bpfd_pkg::OP_COUNT, rand_id(), FLOOD_DST, rand_ts(), '0, TS_MAX);
    end
    case (mix)
      MIX_FILL:  begin add_lim = 80; fwd_lim = 85; cnt_lim = 97; end
      MIX_DRAIN: begin add_lim = 25; fwd_lim = 75; cnt_lim = 97; end
      default:   begin add_lim = 45; fwd_lim = 65; cnt_lim = 95; end
    endcase
    if (r < add_lim)
      return make_item(bpfd_pkg::OP_ADD, pick_id(), pick_id(), pick_time(),
                       rand_ts(), rand_ts());
    if (r < fwd_lim)
      return make_item(bpfd_pkg::OP_FWD, rand_id(), rand_id(), rand_ts(),
                       rand_ts(), rand_ts());
    if (r < cnt_lim)
      return make_item(bpfd_pkg::OP_COUNT, rand_id(), pick_id(), rand_ts(),
                       pick_bound(), pick_bound());
    return make_item(OP_UNUSED, rand_id(), rand_id(), rand_ts(), rand_ts(), rand_ts());
  endfunction

  // Present one item and hold it until the block takes it. Valid stays high
  // between back-to-back items unless the sender decides to idle first.
  task automatic send_item(input bpfd_pkg::in_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_expected();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Change the limit only with the block idle
  task automatic write_limit(input logic [bpfd_pkg::LIMIT_W-1:0] value);
    drain_expected();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    bpfd_pkg::in_t item;
    traffic_mix_e  mix;
    int unsigned   burst;
    int unsigned   accepted_ops;

    flood_ts      = 30'd1000;
    send_idle_pct = 10;
    recv_idle_pct = 85;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_limit(bpfd_pkg::LIMIT_RESET);

    // Directed: empty store, field extremes, duplicates, range edges
    send_item(make_item(bpfd_pkg::OP_FWD, '0, '0, '0, '0, '0));        // forward when empty
    send_item(make_item(bpfd_pkg::OP_COUNT, '0, '0, '0, '0, TS_MAX));  // count when empty
    send_item(make_item(bpfd_pkg::OP_ADD, '0, '0, '0, '0, '0));
    send_item(make_item(bpfd_pkg::OP_ADD, '1, '1, TS_MAX, '0, '0));
    send_item(make_item(bpfd_pkg::OP_ADD, '1, '1, TS_MAX, '1, '1));    // exact duplicate
    send_item(make_item(bpfd_pkg::OP_ADD, 16'd1, '1, 30'd100, '0, '0));
    send_item(make_item(bpfd_pkg::OP_COUNT, '0, '1, '0, '0, TS_MAX));
    send_item(make_item(bpfd_pkg::OP_COUNT, '0, '1, '0, 30'd200, 30'd100)); // reversed range
    send_item(make_item(bpfd_pkg::OP_COUNT, '0, '1, '0, 30'd100, 30'd100)); // inclusive bounds
    send_item(make_item(OP_UNUSED, '1, '1, TS_MAX, TS_MAX, TS_MAX));
    send_item(make_item(bpfd_pkg::OP_FWD, '0, '0, '0, '0, '0));
    send_item(make_item(bpfd_pkg::OP_FWD, '0, '0, '0, '0, '0));
    send_item(make_item(bpfd_pkg::OP_FWD, '1, '1, TS_MAX, TS_MAX, TS_MAX));

    // Small limit: the oldest goes on overflow, and the entry about to be
    // evicted still blocks a duplicate
    write_limit(7'd2);
    send_item(make_item(bpfd_pkg::OP_ADD, 16'd10, 16'd20, 30'd30, '0, '0));
    send_item(make_item(bpfd_pkg::OP_ADD, 16'd11, 16'd20, 30'd31, '0, '0));
    send_item(make_item(bpfd_pkg::OP_ADD, 16'd12, 16'd20, 30'd32, '0, '0));
    send_item(make_item(bpfd_pkg::OP_ADD, 16'd11, 16'd20, 30'd31, '0, '0));
    send_item(make_item(bpfd_pkg::OP_COUNT, '0, 16'd20, '0, '0, TS_MAX));

    // Zero acts as one, and lowering below occupancy evicts just one per add
    write_limit(7'd0);
    send_item(make_item(bpfd_pkg::OP_ADD, 16'd13, 16'd20, 30'd33, '0, '0));
    send_item(make_item(bpfd_pkg::OP_COUNT, '0, 16'd20, '0, 30'd30, 30'd33));

    // Above the store depth acts as the depth
    write_limit(7'd127);
    send_item(make_item(bpfd_pkg::OP_ADD, 16'd14, 16'd20, 30'd34, '0, '0));
    send_item(make_item(bpfd_pkg::OP_COUNT, '0, 16'd20, '0, '0, TS_MAX));

    // Random: three idling regimes, three limit settings each
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_limit(limit_plan[seg]);
      send_idle_pct = (seg < 3) ? 10 : ((seg < 6) ? 85 : 0);
      recv_idle_pct = (seg < 3) ? 85 : ((seg < 6) ? 10 : 0);
      accepted_ops = 0;
      while (accepted_ops < ITEMS_PER_SEG) begin
        mix   = traffic_mix_e'($urandom_range(0, 3));
        burst = (mix == MIX_FLOOD) ? $urandom_range(40, 90) : $urandom_range(10, 40);
        repeat (burst) begin
          // stop the burst once the segment has its share
          if (accepted_ops >= ITEMS_PER_SEG) break;
          item = random_item(mix);
          send_item(item);
          // unknown operations only pass through; do not count them
          if (item.operation != OP_UNUSED) accepted_ops++;
          if ($urandom_range(199) == 0) drain_expected();
        end
      end
    end

    drain_expected();
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bpfd_pkg.sv
hdl/bpfd_dpath.sv
hdl/bpfd_ctrl.sv
hdl/bounded_packet_fifo_dedup_count_unit.sv
verif/bpfd_result_checker.sv
verif/tb.sv
